>>> rtl/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared constants, beat types and ring helpers for the searchable FIFO.
// ----------------------------------------------------------------------------
package fqs_pkg;

  // Ring capacity in words (legal range 2 to 32).
  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths of the two channels.
  localparam int OP_W   = 2;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int POS_W  = 5;
  localparam int MC_W   = 6;
  localparam int LEN_W  = 6;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_MATCH = 3'd3;
  localparam logic [STAT_W-1:0] ST_DONE  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
  } fqs_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [MC_W-1:0]   match_count;
    logic [LEN_W-1:0]  length;
    logic              last;
  } fqs_out_t;

  // Request from the sequencer to the ring store.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } fqs_mem_req_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] slot);
    logic [IDX_W-1:0] nxt;
    if (slot == IDX_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = slot + 1'b1;
    end
    return nxt;
  endfunction

endpackage

>>> rtl/fqs_store.sv
// ----------------------------------------------------------------------------
// fqs_store
// Ring storage with one write port, one registered read port and the single
// word comparator that the search walk reuses for every entry.
// ----------------------------------------------------------------------------
module fqs_store (
  input  logic                                  clk,
  input  fqs_pkg::fqs_mem_req_t                 mem_req,
  input  logic signed [fqs_pkg::VAL_W-1:0]      key,
  output logic                                  hit
);
  import fqs_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  // Full 32-bit equality against the word under search.
  assign hit = (rd_data_r == VAL_W'(key));

endmodule

>>> rtl/fifo_queue_with_search.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// Bounded FIFO of signed words in a ring store, with a head-to-tail search.
// ----------------------------------------------------------------------------
// A push, a pop or an unused operation is taken in idle and carried out in the
// exec state, which registers its result beat and goes back to idle for the
// next input. A search starts its walk in the exec state, reads each held word
// from head to tail in the scan state and sends its closing beat from the done
// state before it goes back to idle; the walk is set by the single read port of
// the ring store and the one comparator that each word goes through in turn.
// Each match sends one beat with its position from the head, and a final beat
// carries the match count; a stalled output channel holds the item where it
// stands. The block holds no input while an item is in work.
module fifo_queue_with_search (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fqs_pkg::fqs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fqs_pkg::fqs_out_t out_data
);
  import fqs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [OP_W-1:0]         op_r, op_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [IDX_W-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic [IDX_W-1:0]        slot_r, slot_nxt;
  logic [CNT_W-1:0]        match_r, match_nxt;
  logic                    out_valid_r, out_valid_nxt;
  fqs_out_t                out_data_r, out_data_nxt;

  fqs_mem_req_t mem_req;
  logic         hit;
  logic         out_free;
  logic         emit;
  fqs_out_t     beat;

  fqs_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .key     (value_r),
    .hit     (hit)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    value_nxt = value_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    slot_nxt  = slot_r;
    match_nxt = match_r;
    mem_req   = '0;
    mem_req.wdata = VAL_W'(value_r);
    emit      = 1'b0;
    beat      = '0;
    beat.length = LEN_W'(count_r);
    beat.last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.operation;
          value_nxt = in_data.value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_r)
          OP_PUSH: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (count_r == CNT_W'(DEPTH)) begin
                beat.status = ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = tail_r;
                tail_nxt      = ring_next(tail_r);
                count_nxt     = count_r + 1'b1;
                beat.status   = ST_OK;
                beat.length   = LEN_W'(count_nxt);
              end
            end
          end
          OP_POP: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (count_r == '0) begin
                beat.status = ST_EMPTY;
              end else begin
                head_nxt    = ring_next(head_r);
                count_nxt   = count_r - 1'b1;
                beat.status = ST_OK;
                beat.length = LEN_W'(count_nxt);
              end
            end
          end
          OP_SEARCH: begin
            pos_nxt   = '0;
            match_nxt = '0;
            if (count_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = head_r;
              slot_nxt      = ring_next(head_r);
              state_nxt     = S_SCAN;
            end
          end
          default: begin
            if (out_free) begin
              emit        = 1'b1;
              beat.status = ST_OK;
              state_nxt   = S_IDLE;
            end
          end
        endcase
      end

      S_SCAN: begin
        // The read data of the word at pos_r is in the store's output
        // register; a match waits here until the output register frees up.
        if (!hit || out_free) begin
          if (hit) begin
            emit          = 1'b1;
            beat.status   = ST_MATCH;
            beat.position = POS_W'(pos_r);
            beat.last     = 1'b0;
            match_nxt     = match_r + 1'b1;
          end
          pos_nxt = pos_r + 1'b1;
          if (pos_nxt == count_r) begin
            state_nxt = S_DONE;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = slot_r;
            slot_nxt      = ring_next(slot_r);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit             = 1'b1;
          beat.status      = ST_DONE;
          beat.match_count = MC_W'(match_r);
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = beat;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_data_nxt  = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      slot_r      <= '0;
      match_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      slot_r      <= slot_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    value_r    <= value_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/fqs_chk.sv
// ----------------------------------------------------------------------------
// fqs_chk
// Port-level checks on the searchable FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module fqs_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input fqs_pkg::fqs_out_t out_data
);
  import fqs_pkg::*;

  // A result beat held back by the sink must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // An accepted item keeps the block busy in the cycle after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // Only match beats leave the item open.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.status == ST_MATCH) == !out_data.last))
    else $error("last flag does not agree with status");

  // The queue never reports more words than it can hold.
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.length <= LEN_W'(DEPTH)))
    else $error("length beyond capacity");

  // A search cannot find more matches than there are words.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_DONE) |->
      (out_data.match_count <= out_data.length))
    else $error("match count exceeds length");

endmodule

bind fifo_queue_with_search fqs_chk u_fqs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
